// ===== design/nir_pkg.sv =====
// Shared types and constants for the NEC IR command receiver.
// Used by the front end, the command back end and the top level.
package nir_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX  = 3'd5;

    // Threshold values after reset.
    localparam logic [BYTE_W-1:0] START_MIN_RST = 8'd60;
    localparam logic [BYTE_W-1:0] START_MAX_RST = 8'd100;
    localparam logic [BYTE_W-1:0] ONE_MIN_RST   = 8'd25;
    localparam logic [BYTE_W-1:0] ONE_MAX_RST   = 8'd45;
    localparam logic [BYTE_W-1:0] ZERO_MIN_RST  = 8'd7;
    localparam logic [BYTE_W-1:0] ZERO_MAX_RST  = 8'd25;

    // Back end state after reset.
    localparam logic [BYTE_W-1:0] GAIN_RST  = 8'd10;
    localparam logic [BYTE_W-1:0] SPEED_RST = 8'hFF;

    localparam logic [BYTE_W-1:0] INV_MATCH   = 8'hFF;
    localparam logic [BYTE_W-1:0] STEP_FINE   = 8'd1;
    localparam logic [BYTE_W-1:0] STEP_COARSE = 8'd10;

    // Command codes.
    localparam logic [BYTE_W-1:0] CMD_RUN_ON     = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_RUN_OFF    = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_GAIN_INC1  = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_GAIN_INC10 = 8'h50;
    localparam logic [BYTE_W-1:0] CMD_GAIN_DEC1  = 8'h90;
    localparam logic [BYTE_W-1:0] CMD_GAIN_DEC10 = 8'hD0;
    localparam logic [BYTE_W-1:0] CMD_SPD_INC1   = 8'h08;
    localparam logic [BYTE_W-1:0] CMD_SPD_INC10  = 8'h48;
    localparam logic [BYTE_W-1:0] CMD_SPD_DEC1   = 8'h88;
    localparam logic [BYTE_W-1:0] CMD_SPD_DEC10  = 8'hC8;

    // Classified edge, passed from the front end to the back end.
    typedef struct packed {
        logic              done;
        logic              ok;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] code;
    } t_token;

    // One result transaction.
    typedef struct packed {
        logic              done;
        logic              ok;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] code;
        logic              run;
        logic [BYTE_W-1:0] gain;
        logic [BYTE_W-1:0] speed;
    } t_result;

endpackage

// ===== design/nir_fifo.sv =====
// Two-entry first-in first-out queue of WIDTH-bit words.
// Stands between the receiver's stages; no package dependency.
module nir_fifo #(
    parameter int unsigned WIDTH = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_do_wr;
    logic             w_do_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_do_wr = i_wr && !o_full;
    assign w_do_rd = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_do_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_do_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_do_wr && !w_do_rd) begin
                r_count <= r_count + 2'd1;
            end else if (w_do_rd && !w_do_wr) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== design/nir_front.sv =====
// Front end: threshold registers, gap classification and frame assembly.
// Depends on nir_pkg for the token type and register indexes.
module nir_front #(
    parameter int unsigned FRAME_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [nir_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [nir_pkg::BYTE_W-1:0]           i_cfg_data,
    input  logic                                 i_edge_valid,
    input  logic [nir_pkg::BYTE_W-1:0]           i_edge_time,
    output nir_pkg::t_token                      o_token
);

    localparam int unsigned CNT_W = $clog2(FRAME_BITS + 2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BITS);

    logic [nir_pkg::BYTE_W-1:0] r_start_min, r_start_max;
    logic [nir_pkg::BYTE_W-1:0] r_one_min, r_one_max;
    logic [nir_pkg::BYTE_W-1:0] r_zero_min, r_zero_max;

    logic [nir_pkg::BYTE_W-1:0] r_prev_edge;
    logic [FRAME_BITS-1:0]      r_shift;
    logic [CNT_W-1:0]           r_count;

    logic [nir_pkg::BYTE_W-1:0] w_gap;
    logic                       w_is_start, w_is_one, w_is_zero;
    logic [FRAME_BITS-1:0]      w_sh0, w_sh1, n_shift;
    logic [CNT_W-1:0]           w_cnt0, w_cnt1, w_cnt2;
    logic                       w_done;
    logic [nir_pkg::BYTE_W-1:0] w_cmd, w_inv;
    logic [CNT_W-1:0]           n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_min <= nir_pkg::START_MIN_RST;
            r_start_max <= nir_pkg::START_MAX_RST;
            r_one_min   <= nir_pkg::ONE_MIN_RST;
            r_one_max   <= nir_pkg::ONE_MAX_RST;
            r_zero_min  <= nir_pkg::ZERO_MIN_RST;
            r_zero_max  <= nir_pkg::ZERO_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nir_pkg::CFG_START_MIN: r_start_min <= i_cfg_data;
                nir_pkg::CFG_START_MAX: r_start_max <= i_cfg_data;
                nir_pkg::CFG_ONE_MIN:   r_one_min   <= i_cfg_data;
                nir_pkg::CFG_ONE_MAX:   r_one_max   <= i_cfg_data;
                nir_pkg::CFG_ZERO_MIN:  r_zero_min  <= i_cfg_data;
                nir_pkg::CFG_ZERO_MAX:  r_zero_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The three windows are applied in order, so one gap can clear the frame
    // and then shift a bit, or shift a one followed by a zero.
    always_comb begin
        w_gap      = i_edge_time - r_prev_edge;
        w_is_start = (w_gap > r_start_min) && (w_gap < r_start_max);
        w_is_one   = (w_gap > r_one_min) && (w_gap < r_one_max);
        w_is_zero  = (w_gap > r_zero_min) && (w_gap < r_zero_max);

        w_sh0  = w_is_start ? '0 : r_shift;
        w_cnt0 = w_is_start ? '0 : r_count;
        w_sh1  = w_is_one ? {w_sh0[FRAME_BITS-2:0], 1'b1} : w_sh0;
        w_cnt1 = w_is_one ? w_cnt0 + CNT_W'(1) : w_cnt0;
        n_shift = w_is_zero ? {w_sh1[FRAME_BITS-2:0], 1'b0} : w_sh1;
        w_cnt2  = w_is_zero ? w_cnt1 + CNT_W'(1) : w_cnt1;

        w_done  = (w_cnt2 >= CNT_FULL);
        n_count = w_done ? '0 : w_cnt2;
        w_cmd   = n_shift[15:8];
        w_inv   = n_shift[7:0];

        o_token.done = w_done;
        o_token.ok   = w_done && ((w_cmd ^ w_inv) == nir_pkg::INV_MATCH);
        o_token.addr = w_done ? n_shift[FRAME_BITS-1 -: nir_pkg::BYTE_W] : '0;
        o_token.code = w_done ? w_cmd : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_edge <= '0;
            r_shift     <= '0;
            r_count     <= '0;
        end else if (i_edge_valid) begin
            r_prev_edge <= i_edge_time;
            r_shift     <= n_shift;
            r_count     <= n_count;
        end
    end

endmodule

// ===== design/nir_back.sv =====
// Back end: applies verified command codes to the run, gain and speed state.
// Depends on nir_pkg for the token and result types and the command codes.
module nir_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  nir_pkg::t_token  i_token,
    output nir_pkg::t_result o_result
);

    logic                       r_run;
    logic [nir_pkg::BYTE_W-1:0] r_gain;
    logic [nir_pkg::BYTE_W-1:0] r_speed;
    logic                       n_run;
    logic [nir_pkg::BYTE_W-1:0] n_gain;
    logic [nir_pkg::BYTE_W-1:0] n_speed;

    always_comb begin
        n_run   = r_run;
        n_gain  = r_gain;
        n_speed = r_speed;
        if (i_token.ok) begin
            case (i_token.code)
                nir_pkg::CMD_RUN_ON:     n_run   = 1'b1;
                nir_pkg::CMD_RUN_OFF:    n_run   = 1'b0;
                nir_pkg::CMD_GAIN_INC1:  n_gain  = r_gain + nir_pkg::STEP_FINE;
                nir_pkg::CMD_GAIN_INC10: n_gain  = r_gain + nir_pkg::STEP_COARSE;
                nir_pkg::CMD_GAIN_DEC1:  n_gain  = r_gain - nir_pkg::STEP_FINE;
                nir_pkg::CMD_GAIN_DEC10: n_gain  = r_gain - nir_pkg::STEP_COARSE;
                nir_pkg::CMD_SPD_INC1:   n_speed = r_speed + nir_pkg::STEP_FINE;
                nir_pkg::CMD_SPD_INC10:  n_speed = r_speed + nir_pkg::STEP_COARSE;
                nir_pkg::CMD_SPD_DEC1:   n_speed = r_speed - nir_pkg::STEP_FINE;
                nir_pkg::CMD_SPD_DEC10:  n_speed = r_speed - nir_pkg::STEP_COARSE;
                default: ;
            endcase
        end

        o_result.done  = i_token.done;
        o_result.ok    = i_token.ok;
        o_result.addr  = i_token.addr;
        o_result.code  = i_token.code;
        o_result.run   = n_run;
        o_result.gain  = n_gain;
        o_result.speed = n_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_gain  <= nir_pkg::GAIN_RST;
            r_speed <= nir_pkg::SPEED_RST;
        end else if (i_take) begin
            r_run   <= n_run;
            r_gain  <= n_gain;
            r_speed <= n_speed;
        end
    end

endmodule

// ===== design/nec_ir_command_receiver.sv =====
// NEC IR command receiver. Each push carries the timestamp of one rising IR
// edge and yields exactly one result, so one edge can be taken every clock
// cycle while full is low: the front end classifies the gap and assembles
// the frame in the accept cycle, a two-entry queue hands its transaction to
// the command back end, and a two-entry output queue holds results until
// popped. A result reaches the output ports after its token is registered in
// the first queue and then, once the output queue has room, in the output queue.
// Configuration writes are always ready and take effect on the next edge.
// Depends on nir_pkg, nir_fifo, nir_front and nir_back.
module nec_ir_command_receiver #(
    parameter int unsigned FRAME_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [nir_pkg::BYTE_W-1:0]    i_edge_time,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_frame_done,
    output logic                          o_command_ok,
    output logic [nir_pkg::BYTE_W-1:0]    o_device_address,
    output logic [nir_pkg::BYTE_W-1:0]    o_command_code,
    output logic                          o_run_enabled,
    output logic [nir_pkg::BYTE_W-1:0]    o_gain_value,
    output logic [nir_pkg::BYTE_W-1:0]    o_speed_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nir_pkg::BYTE_W-1:0]    i_cfg_data
);

    localparam int unsigned TOK_W = $bits(nir_pkg::t_token);
    localparam int unsigned RES_W = $bits(nir_pkg::t_result);

    logic             w_accept;
    nir_pkg::t_token  w_front_tok;
    nir_pkg::t_token  w_mid_tok;
    logic             w_mid_empty;
    logic             w_out_full;
    logic             w_take;
    nir_pkg::t_result w_back_res;
    nir_pkg::t_result w_out_res;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = push && !full;
    assign w_take      = !w_mid_empty && !w_out_full;

    nir_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_edge_valid (w_accept),
        .i_edge_time  (i_edge_time),
        .o_token      (w_front_tok)
    );

    nir_fifo #(
        .WIDTH (TOK_W)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_data  (w_front_tok),
        .o_full  (full),
        .i_rd    (w_take),
        .o_empty (w_mid_empty),
        .o_data  (w_mid_tok)
    );

    nir_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_token  (w_mid_tok),
        .o_result (w_back_res)
    );

    nir_fifo #(
        .WIDTH (RES_W)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_take),
        .i_data  (w_back_res),
        .o_full  (w_out_full),
        .i_rd    (pop),
        .o_empty (empty),
        .o_data  (w_out_res)
    );

    assign o_frame_done     = w_out_res.done;
    assign o_command_ok     = w_out_res.ok;
    assign o_device_address = w_out_res.addr;
    assign o_command_code   = w_out_res.code;
    assign o_run_enabled    = w_out_res.run;
    assign o_gain_value     = w_out_res.gain;
    assign o_speed_value    = w_out_res.speed;

endmodule
